// ----- rtl/lfp_pkg.sv -----
package lfp_pkg;

  // Widths of the slot arithmetic.
  localparam int DIV_W   = 34;
  localparam int DCNT_W  = 6;
  localparam int TOT_W   = 25;

  localparam logic [31:0] RANGE_MAGIC = 32'h4849534E;
  localparam logic [39:0] AREA_MAGIC  = 40'h5753696D75;
  localparam logic [8:0]  DEG_FULL    = 9'd360;

  localparam logic [1:0] KIND_POINT = 2'd0;
  localparam logic [1:0] KIND_AREA  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic REG_MAX_DIST  = 1'b0;
  localparam logic REG_INT_LIMIT = 1'b1;

  localparam int RANGE_HEADER_BYTES_DEF = 16;
  localparam int AREA_FRAME_BYTES_DEF   = 23;

  typedef enum logic [4:0] {
    PH_HUNT   = 5'b00001,
    PH_HEAD   = 5'b00010,
    PH_POINTS = 5'b00100,
    PH_TAIL   = 5'b01000,
    PH_AREA   = 5'b10000
  } phase_t;

  typedef enum logic [8:0] {
    CS_IDLE  = 9'b000000001,
    CS_SPAN  = 9'b000000010,
    CS_MUL   = 9'b000000100,
    CS_SUM   = 9'b000001000,
    CS_DIVT  = 9'b000010000,
    CS_WAITT = 9'b000100000,
    CS_DIVF  = 9'b001000000,
    CS_WAITF = 9'b010000000,
    CS_FIN   = 9'b100000000
  } ctrl_state_t;

  typedef struct packed {
    logic busy;
    logic span_en;
    logic mul_en;
    logic sum_en;
    logic div_start;
    logic div_sel;
    logic tot_en;
    logic fin_en;
  } cmd_t;

  typedef struct packed {
    logic hdr_last;
    logic span_bad;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/lfp_div.sv -----
module lfp_div
  import lfp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [15:0]      divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic              busy_r, busy_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]       rem_r, rem_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic              done_r, done_nxt;

  always_comb begin
    logic [16:0] shifted;
    logic        ge;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, quo_r[DIV_W-1]};
    ge       = shifted >= {1'b0, divisor};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? 16'(shifted - {1'b0, divisor}) : shifted[15:0];
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DCNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/lfp_ctrl.sv -----
module lfp_ctrl
  import lfp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  sts_t sts,
  output cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.busy  = state_r != CS_IDLE;
    unique case (state_r)
      CS_IDLE:  if (sts.hdr_last) state_nxt = CS_SPAN;
      CS_SPAN: begin
        cmd.span_en = 1'b1;
        state_nxt   = CS_MUL;
      end
      CS_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = sts.span_bad ? CS_FIN : CS_SUM;
      end
      CS_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = CS_DIVT;
      end
      CS_DIVT: begin
        cmd.div_start = 1'b1;
        state_nxt     = CS_WAITT;
      end
      CS_WAITT: if (sts.div_done) begin
        cmd.tot_en = 1'b1;
        state_nxt  = CS_DIVF;
      end
      CS_DIVF: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
        state_nxt     = CS_WAITF;
      end
      CS_WAITF: begin
        cmd.div_sel = 1'b1;
        if (sts.div_done) state_nxt = CS_FIN;
      end
      CS_FIN: if (sts.out_free) begin
        cmd.fin_en = 1'b1;
        state_nxt  = CS_IDLE;
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/lfp_dp.sv -----
module lfp_dp
  import lfp_pkg::*;
#(
  parameter int RANGE_HEADER_BYTES = RANGE_HEADER_BYTES_DEF,
  parameter int AREA_FRAME_BYTES   = AREA_FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [15:0] max_distance,
  input  logic [15:0] intensity_limit,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [15:0] out_point_index,
  output logic [15:0] out_distance,
  output logic [15:0] out_intensity,
  output logic [15:0] out_scan_points,
  output logic        out_scan_end,
  output logic [7:0]  out_area_channel,
  output logic [7:0]  out_area_status
);

  localparam logic [15:0] TAIL_LEN = 16'(RANGE_HEADER_BYTES - 16);
  localparam logic [15:0] AREA_LEN = 16'(AREA_FRAME_BYTES);

  phase_t        phase_r, phase_nxt;
  logic [39:0]   win_r, win_nxt;
  logic [15:0]   cnt_r, cnt_nxt;
  logic [15:0]   start_r, start_nxt, end_r, end_nxt, pts_r, pts_nxt;
  logic [15:0]   pos_r, pos_nxt, ppf_r, ppf_nxt;
  logic [1:0]    lane_r, lane_nxt;
  logic [23:0]   pbytes_r, pbytes_nxt;
  logic [7:0]    ch_r, ch_nxt;
  logic signed [31:0] first_r;
  logic [15:0]   total16_r;
  logic signed [17:0] span_r;
  logic [TOT_W-1:0]   totp_r, total_r;
  logic [31:0]        proda_r;
  logic signed [33:0] prodb_r;
  logic               neg_r;
  logic [DIV_W-1:0]   mag_r;

  logic        out_valid_r;
  logic [1:0]  kind_r;
  logic [15:0] idx_r, dist_r, inten_r, slots_r;
  logic        end_flag_r;
  logic [7:0]  och_r, ost_r;

  logic        emit;
  logic [1:0]  e_kind;
  logic [15:0] e_idx, e_dist, e_inten, e_slots;
  logic        e_end;
  logic [7:0]  e_ch, e_st;

  logic             in_fire, out_take;
  logic             div_done;
  logic [DIV_W-1:0] quotient;

  assign out_take = out_valid_r && !out_stall;
  assign in_stall = cmd.busy || (out_valid_r && out_stall);
  assign in_fire  = in_valid && !in_stall;

  assign sts.hdr_last = in_fire && (phase_r == PH_HEAD) && (cnt_r >= 16'd15);
  assign sts.span_bad = (span_r <= 18'sd0) || (ppf_r == 16'd0);
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || !out_stall;

  lfp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (cmd.div_sel ? mag_r : DIV_W'(totp_r)),
    .divisor  (span_r[15:0]),
    .done     (div_done),
    .quotient (quotient)
  );

  // Byte parser.
  always_comb begin
    logic [39:0]        w;
    logic signed [33:0] slot;
    logic               last;
    phase_nxt  = phase_r;
    win_nxt    = win_r;
    cnt_nxt    = cnt_r;
    start_nxt  = start_r;
    end_nxt    = end_r;
    pts_nxt    = pts_r;
    pos_nxt    = pos_r;
    ppf_nxt    = ppf_r;
    lane_nxt   = lane_r;
    pbytes_nxt = pbytes_r;
    ch_nxt     = ch_r;
    emit = 1'b0; e_kind = KIND_POINT; e_idx = '0; e_dist = '0; e_inten = '0;
    e_slots = '0; e_end = 1'b0; e_ch = '0; e_st = '0;
    w    = {win_r[31:0], in_stream_byte};
    slot = $signed({{2{first_r[31]}}, first_r}) + $signed({18'd0, cnt_r});
    last = (17'(cnt_r) + 17'd1) >= {1'b0, pts_r};
    if (in_fire) begin
      unique case (phase_r)
        PH_HEAD: begin
          cnt_nxt = cnt_r + 16'd1;
          unique case (cnt_r)
            16'd4:   start_nxt = {in_stream_byte, 8'd0};
            16'd5:   start_nxt = {start_r[15:8], in_stream_byte};
            16'd6:   end_nxt   = {in_stream_byte, 8'd0};
            16'd7:   end_nxt   = {end_r[15:8], in_stream_byte};
            16'd8:   pts_nxt   = {in_stream_byte, 8'd0};
            16'd9:   pts_nxt   = {pts_r[15:8], in_stream_byte};
            16'd10:  pos_nxt   = {in_stream_byte, 8'd0};
            16'd11:  pos_nxt   = {pos_r[15:8], in_stream_byte};
            16'd12:  ppf_nxt   = {in_stream_byte, 8'd0};
            16'd13:  ppf_nxt   = {ppf_r[15:8], in_stream_byte};
            default: ;
          endcase
          if (cnt_r >= 16'd15) begin
            cnt_nxt    = '0;
            lane_nxt   = '0;
            pbytes_nxt = '0;
            if (pts_r == 16'd0) begin
              phase_nxt = (TAIL_LEN != 16'd0) ? PH_TAIL : PH_HUNT;
            end else begin
              phase_nxt = PH_POINTS;
            end
          end
        end
        PH_POINTS: begin
          if (lane_r != 2'd3) begin
            unique case (lane_r)
              2'd0:    pbytes_nxt[7:0]   = in_stream_byte;
              2'd1:    pbytes_nxt[15:8]  = in_stream_byte;
              default: pbytes_nxt[23:16] = in_stream_byte;
            endcase
            lane_nxt = lane_r + 2'd1;
          end else begin
            lane_nxt   = '0;
            pbytes_nxt = '0;
            cnt_nxt    = cnt_r + 16'd1;
            if (last) begin
              cnt_nxt   = '0;
              phase_nxt = (TAIL_LEN != 16'd0) ? PH_TAIL : PH_HUNT;
            end
            if (total16_r != 16'd0) begin
              emit    = 1'b1;
              e_slots = total16_r;
              e_end   = last && (end_r == 16'd0) && (pos_r == ppf_r);
              if (slot < 34'sd0 || slot >= $signed({18'd0, total16_r})) begin
                e_kind = KIND_ERROR;
              end else begin
                e_idx   = slot[15:0];
                e_dist  = (pbytes_r[15:0] > max_distance) ? max_distance
                                                          : pbytes_r[15:0];
                e_inten = ({in_stream_byte, pbytes_r[23:16]} > intensity_limit)
                          ? 16'd0 : {in_stream_byte, pbytes_r[23:16]};
              end
            end
          end
        end
        PH_TAIL: begin
          cnt_nxt = cnt_r + 16'd1;
          if (cnt_r + 16'd1 >= TAIL_LEN) begin
            cnt_nxt   = '0;
            phase_nxt = PH_HUNT;
          end
        end
        PH_AREA: begin
          cnt_nxt = cnt_r + 16'd1;
          if (cnt_r == 16'd5) ch_nxt = in_stream_byte;
          if (cnt_r == 16'd7) pbytes_nxt = {16'd0, in_stream_byte};
          if ((17'(cnt_r) + 17'd1) >= {1'b0, AREA_LEN}) begin
            emit       = 1'b1;
            e_kind     = KIND_AREA;
            e_ch       = ch_r;
            e_st       = (cnt_r == 16'd7) ? in_stream_byte : pbytes_r[7:0];
            cnt_nxt    = '0;
            pbytes_nxt = '0;
            phase_nxt  = PH_HUNT;
          end
        end
        default: begin
          win_nxt = w;
          if (w[31:0] == RANGE_MAGIC) begin
            win_nxt   = '0;
            cnt_nxt   = 16'd4;
            phase_nxt = PH_HEAD;
          end else if (w == AREA_MAGIC) begin
            win_nxt    = '0;
            cnt_nxt    = 16'd5;
            pbytes_nxt = '0;
            ch_nxt     = '0;
            phase_nxt  = PH_AREA;
          end
        end
      endcase
    end
    if (cmd.fin_en && (sts.span_bad || total_r == '0 || total_r > TOT_W'(65535))) begin
      emit   = 1'b1;
      e_kind = KIND_ERROR;
    end
  end

  // Slot arithmetic and registers.
  always_ff @(posedge clk) begin
    logic [17:0]        diff;
    logic signed [16:0] dpos;
    logic signed [33:0] num;
    logic               ok;
    diff = {2'b0, end_r} - {2'b0, start_r};
    dpos = $signed({1'b0, pos_r}) - $signed({1'b0, pts_r});
    num  = $signed({2'b0, proda_r}) + prodb_r;
    ok   = !sts.span_bad && total_r != '0 && total_r <= TOT_W'(65535);
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      win_r       <= '0;
      cnt_r       <= '0;
      start_r     <= '0;
      end_r       <= '0;
      pts_r       <= '0;
      pos_r       <= '0;
      ppf_r       <= '0;
      lane_r      <= '0;
      pbytes_r    <= '0;
      ch_r        <= '0;
      first_r     <= '0;
      total16_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      win_r    <= win_nxt;
      cnt_r    <= cnt_nxt;
      start_r  <= start_nxt;
      end_r    <= end_nxt;
      pts_r    <= pts_nxt;
      pos_r    <= pos_nxt;
      ppf_r    <= ppf_nxt;
      lane_r   <= lane_nxt;
      pbytes_r <= pbytes_nxt;
      ch_r     <= ch_nxt;
      if (cmd.fin_en) begin
        total16_r <= ok ? total_r[15:0] : 16'd0;
        if (neg_r) begin
          first_r <= (quotient > DIV_W'(34'h080000000)) ? 32'sh80000000
                                                         : -$signed(quotient[31:0]);
        end else begin
          first_r <= (quotient > DIV_W'(34'h07FFFFFFF)) ? 32'sh7FFFFFFF
                                                         : $signed(quotient[31:0]);
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
    if (cmd.span_en) begin
      span_r <= diff[17] ? $signed(diff + 18'(DEG_FULL)) : $signed(diff);
    end
    if (cmd.mul_en) begin
      totp_r  <= ppf_r * DEG_FULL;
      proda_r <= start_r * ppf_r;
      prodb_r <= dpos * $signed({1'b0, span_r[15:0]});
    end
    if (cmd.sum_en) begin
      neg_r <= num[33];
      mag_r <= num[33] ? DIV_W'(-num) : DIV_W'(num);
    end
    if (cmd.tot_en) begin
      total_r <= quotient[TOT_W-1:0];
    end
    if (emit) begin
      kind_r     <= e_kind;
      idx_r      <= e_idx;
      dist_r     <= e_dist;
      inten_r    <= e_inten;
      slots_r    <= e_slots;
      end_flag_r <= e_end;
      och_r      <= e_ch;
      ost_r      <= e_st;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = kind_r;
  assign out_point_index  = idx_r;
  assign out_distance     = dist_r;
  assign out_intensity    = inten_r;
  assign out_scan_points  = slots_r;
  assign out_scan_end     = end_flag_r;
  assign out_area_channel = och_r;
  assign out_area_status  = ost_r;

endmodule

// ----- rtl/lidar_frame_parser.sv -----
// Ordinary bytes are taken one per cycle unless stalled; a result appears in the cycle
// after its byte. The last header byte of a range frame starts the slot arithmetic,
// during which no byte is taken: set-up, two 34-step divisions each waited on, and a
// finish that waits while a result is stalled; a bad span skips from multiply to finish.
// A result held under an output stall blocks the input. Synchronous active-low reset
// returns the parser to magic hunting and sets both limit registers to 65535.
module lidar_frame_parser
  import lfp_pkg::*;
#(
  parameter int RANGE_HEADER_BYTES = RANGE_HEADER_BYTES_DEF,
  parameter int AREA_FRAME_BYTES   = AREA_FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [15:0] out_point_index,
  output logic [15:0] out_distance,
  output logic [15:0] out_intensity,
  output logic [15:0] out_scan_points,
  output logic        out_scan_end,
  output logic [7:0]  out_area_channel,
  output logic [7:0]  out_area_status
);

  // The two limit registers sit at byte addresses 0 and 4; a write transfer
  // completes in its access phase, and reads return the stored limit.
  logic [15:0] max_dist_r, int_limit_r;
  cmd_t        cmd;
  sts_t        sts;

  assign pready = 1'b1;
  assign prdata = {16'd0, (paddr[2] == REG_INT_LIMIT) ? int_limit_r : max_dist_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dist_r  <= 16'hFFFF;
      int_limit_r <= 16'hFFFF;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_MAX_DIST) begin
        max_dist_r <= pwdata[15:0];
      end else begin
        int_limit_r <= pwdata[15:0];
      end
    end
  end

  // The controller sequences the per-frame slot arithmetic; the datapath
  // parses bytes and owns the output register.
  lfp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  lfp_dp #(
    .RANGE_HEADER_BYTES (RANGE_HEADER_BYTES),
    .AREA_FRAME_BYTES   (AREA_FRAME_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .max_distance     (max_dist_r),
    .intensity_limit  (int_limit_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_stream_byte   (in_stream_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_point_index  (out_point_index),
    .out_distance     (out_distance),
    .out_intensity    (out_intensity),
    .out_scan_points  (out_scan_points),
    .out_scan_end     (out_scan_end),
    .out_area_channel (out_area_channel),
    .out_area_status  (out_area_status)
  );

endmodule

// ----- rtl/lfp_checker.sv -----
module lfp_checker
  import lfp_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_result_kind,
  input logic [15:0] out_point_index,
  input logic [15:0] out_distance,
  input logic [15:0] out_intensity
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("byte taken while result held");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_kind != 2'd3)
    else $error("illegal result kind");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_ERROR || out_result_kind == KIND_AREA)
    |-> out_point_index == 16'd0 && out_distance == 16'd0 && out_intensity == 16'd0)
    else $error("point fields set on non-point result");

endmodule

bind lidar_frame_parser lfp_checker u_lfp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_result_kind (out_result_kind),
  .out_point_index (out_point_index),
  .out_distance    (out_distance),
  .out_intensity   (out_intensity)
);
